@@ src/bqc_pkg.sv @@
// shared types, constants and status codes for the bracket and quote continuation checker
package bqc_pkg;

  localparam int CH_W        = 8;
  localparam int LEN_W       = 25;
  localparam int STATUS_W    = 3;
  localparam int CODE_W      = 2;
  localparam int STACK_DEPTH_DEF = 64;

  localparam logic [LEN_W-1:0] LEN_LIMIT_RESET = 25'd16781312;

  localparam logic [STATUS_W-1:0] ST_COMPLETE  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OPEN      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

  localparam logic [CODE_W-1:0] CODE_BRACE = 2'd0;
  localparam logic [CODE_W-1:0] CODE_BRACK = 2'd1;
  localparam logic [CODE_W-1:0] CODE_PAREN = 2'd2;

  localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CH_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CH_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CH_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            is_end;
  } in_word_t;

  typedef struct packed {
    logic                need_more;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage

@@ src/bqc_in_stage.sv @@
// input register for incoming words
module bqc_in_stage
  import bqc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  input  logic       take,
  output stage_ctl_t ctl,
  output in_word_t   word
);

  logic     valid_r;
  logic     valid_nxt;
  in_word_t word_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_data;
    end
  end

  assign ctl.valid = valid_r;
  assign ctl.take  = take;
  assign word      = word_r;

endmodule

@@ src/bqc_scan.sv @@
// line state, bracket stack and terminator status logic
module bqc_scan
  import bqc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             fire,
  input  in_word_t         word,
  output logic             res_valid,
  output out_word_t        res
);

  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);

  logic [LEN_W-1:0]  max_len_r;
  logic              dq_r, dq_nxt;
  logic              sq_r, sq_nxt;
  logic              esc_r, esc_nxt;
  logic [LEN_W-1:0]  count_r, count_nxt;
  logic              mm_r, mm_nxt;
  logic              ov_r, ov_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [CODE_W-1:0] top_r;

  logic [CODE_W-1:0] mem [STACK_DEPTH];
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [CODE_W-1:0] wdata;
  logic [CODE_W-1:0] close_code;
  logic              is_close;

  always_comb begin
    dq_nxt     = dq_r;
    sq_nxt     = sq_r;
    esc_nxt    = esc_r;
    count_nxt  = count_r;
    mm_nxt     = mm_r;
    ov_nxt     = ov_r;
    level_nxt  = level_r;
    we         = 1'b0;
    waddr      = ADDR_W'(level_r);
    wdata      = CODE_BRACE;
    close_code = CODE_BRACE;
    is_close   = 1'b0;
    res_valid  = 1'b0;
    res.need_more = 1'b0;
    res.status    = ST_COMPLETE;

    if (mm_r) begin
      res.status = ST_MISMATCH;
    end else if (ov_r) begin
      res.status = ST_OVERFLOW;
    end else if (count_r > max_len_r) begin
      res.status = ST_TOO_LONG;
    end else if (dq_r || sq_r || (level_r != '0)) begin
      res.status    = ST_OPEN;
      res.need_more = 1'b1;
    end

    if (fire && word.is_end) begin
      res_valid = 1'b1;
      dq_nxt    = 1'b0;
      sq_nxt    = 1'b0;
      esc_nxt   = 1'b0;
      count_nxt = '0;
      mm_nxt    = 1'b0;
      ov_nxt    = 1'b0;
      level_nxt = '0;
    end else if (fire && !mm_r && !ov_r) begin
      if (count_r != '1) begin
        count_nxt = count_r + LEN_W'(1);
      end
      if (word.ch == CH_BSLASH) begin
        esc_nxt = (count_r == '0) ? 1'b0 : !esc_r;
      end else begin
        esc_nxt = 1'b0;
      end
      if (word.ch == CH_DQUOTE && !sq_r && !esc_r) begin
        dq_nxt = !dq_r;
      end
      if (word.ch == CH_SQUOTE && !dq_r && !esc_r) begin
        sq_nxt = !sq_r;
      end

      if (!dq_nxt && !sq_nxt) begin
        case (word.ch) inside
          CH_LBRACE, CH_LBRACK, CH_LPAREN: begin
            if (level_r < LVL_FULL) begin
              we        = 1'b1;
              level_nxt = level_r + LVL_W'(1);
              if (word.ch == CH_LBRACE) begin
                wdata = CODE_BRACE;
              end else if (word.ch == CH_LBRACK) begin
                wdata = CODE_BRACK;
              end else begin
                wdata = CODE_PAREN;
              end
            end else begin
              ov_nxt = 1'b1;
            end
          end
          CH_RBRACE: begin
            is_close   = 1'b1;
            close_code = CODE_BRACE;
          end
          CH_RBRACK: begin
            is_close   = 1'b1;
            close_code = CODE_BRACK;
          end
          CH_RPAREN: begin
            is_close   = 1'b1;
            close_code = CODE_PAREN;
          end
          default: begin
          end
        endcase

        if (is_close) begin
          if ((level_r != '0) && (top_r == close_code)) begin
            level_nxt = level_r - LVL_W'(1);
          end else begin
            mm_nxt = 1'b1;
          end
        end
      end
    end
  end

  assign raddr = (level_nxt == '0) ? '0 : ADDR_W'(level_nxt - LVL_W'(1));

  // top of stack tracks the entry below the next level
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      top_r <= wdata;
    end else begin
      top_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= LEN_LIMIT_RESET;
      dq_r      <= 1'b0;
      sq_r      <= 1'b0;
      esc_r     <= 1'b0;
      count_r   <= '0;
      mm_r      <= 1'b0;
      ov_r      <= 1'b0;
      level_r   <= '0;
    end else begin
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
      dq_r    <= dq_nxt;
      sq_r    <= sq_nxt;
      esc_r   <= esc_nxt;
      count_r <= count_nxt;
      mm_r    <= mm_nxt;
      ov_r    <= ov_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

@@ src/bqc_out_stage.sv @@
// result register toward the output channel
module bqc_out_stage
  import bqc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  input  out_word_t res,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic      valid_r;
  logic      valid_nxt;
  out_word_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = res_valid ? 1'b1 : ((valid_r && out_ready) ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ src/bracket_quote_continuation_check_core.sv @@
// top level of the bracket and quote continuation checker
// The block takes one line of text a byte per word and reports on the terminator word whether
// the line must continue; a new word is taken every cycle unless a terminator word is held
// while the result register is occupied. The bracket stack is a STACK_DEPTH entry memory
// whose top entry is kept in a register refreshed every cycle, so pushes and pops run at full
// rate. Byte words produce no result. The user must write the max_len register through cfg_we
// and cfg_wdata only while the block is idle; the block itself does not enforce it.
module bracket_quote_continuation_check_core
  import bqc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data
);

  stage_ctl_t in_ctl;
  in_word_t   word;
  logic       take;
  logic       can_load;
  logic       res_valid;
  out_word_t  res;

  // terminator words wait for room in the result register
  assign take = in_ctl.valid && (!word.is_end || can_load);

  bqc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .take     (take),
    .ctl      (in_ctl),
    .word     (word)
  );

  bqc_scan #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (in_ctl.take),
    .word      (word),
    .res_valid (res_valid),
    .res       (res)
  );

  bqc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
